// ===== sv/lpg_pkg.sv =====
// Shared types and constants for the LED palette gradient pixel block.
`default_nettype none

package lpg_pkg;

    // Number of LEDs on the strip when the top level is not told otherwise.
    localparam int LED_COUNT_DEF = 31;

    // Payload widths of the stream channels.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    // Largest legal animation phase.
    localparam logic [10:0] PHASE_MAX = 11'd1535;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE  = 3'd0,
        CFG_PARAM = 3'd1,
        CFG_PAL0  = 3'd2,
        CFG_PAL1  = 3'd3,
        CFG_PAL2  = 3'd4,
        CFG_PAL3  = 3'd5,
        CFG_PAL4  = 3'd6,
        CFG_PAL5  = 3'd7
    } t_cfg_reg;

    // Effect modes. Codes six and seven behave as MODE_ALL.
    typedef enum logic [2:0] {
        MODE_ALL        = 3'd0,
        MODE_RADIAL     = 3'd1,
        MODE_CLOCK      = 3'd2,
        MODE_RADIAL_MIX = 3'd3,
        MODE_SPIRAL     = 3'd4,
        MODE_TREE       = 3'd5
    } t_mode;

    // Reset values of the configuration registers.
    localparam logic [2:0]  MODE_RST  = 3'd2;
    localparam logic [30:0] PARAM_RST = 31'd11;
    localparam logic [23:0] PAL_RST [6] = '{
        24'h0000FF, 24'h2BFFFF, 24'h55FFFF, 24'h80FFFF, 24'hABFFFF, 24'hD4FFFF
    };

    // Clock-mode override values derived from the effect parameter.
    typedef struct packed {
        logic [2:0] bright;   // (param / 7) mod 5
        logic [1:0] sat_div;  // (param / 11) mod 3
    } t_clk_ovr;

endpackage

`default_nettype wire

// ===== sv/lpg_param_res.sv =====
// Residue pipeline that derives the clock-mode override values from the effect parameter.
`default_nettype none

module lpg_param_res
    import lpg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [30:0] i_param,
    output t_clk_ovr         o_ovr
);

    // First step: digit sums. 8 = 1 mod 7, 16 = 1 mod 5, 1024 = 1 mod 33.
    logic [6:0]  n_s7;
    logic [6:0]  n_s5;
    logic [11:0] n_s33;
    logic [6:0]  r_s7;
    logic [6:0]  r_s5;
    logic [11:0] r_s33;

    always_comb begin
        logic [32:0] v_oct;
        logic [31:0] v_hex;
        logic [39:0] v_k;
        v_oct = {2'b00, i_param};
        v_hex = {1'b0, i_param};
        v_k   = {9'd0, i_param};
        n_s7  = '0;
        n_s5  = '0;
        n_s33 = '0;
        for (int i = 0; i < 11; i++) begin
            n_s7 = n_s7 + 7'(v_oct[3*i +: 3]);
        end
        for (int i = 0; i < 8; i++) begin
            n_s5 = n_s5 + 7'(v_hex[4*i +: 4]);
        end
        for (int i = 0; i < 4; i++) begin
            n_s33 = n_s33 + 12'(v_k[10*i +: 10]);
        end
    end

    // Second step: fold the sums down to small residues.
    logic [2:0]  n_m7;
    logic [2:0]  n_m5;
    logic [10:0] n_m33;
    logic [2:0]  r_m7;
    logic [2:0]  r_m5;
    logic [10:0] r_m33;

    always_comb begin
        logic [3:0] v_t7;
        logic [4:0] v_t5;
        v_t7 = 4'(r_s7[6]) + 4'(r_s7[5:3]) + 4'(r_s7[2:0]);
        if (v_t7 >= 4'd14) begin
            v_t7 = v_t7 - 4'd14;
        end else if (v_t7 >= 4'd7) begin
            v_t7 = v_t7 - 4'd7;
        end
        n_m7 = v_t7[2:0];
        v_t5 = 5'(r_s5[6:4]) + 5'(r_s5[3:0]);
        if (v_t5 >= 5'd20) begin
            v_t5 = v_t5 - 5'd20;
        end else if (v_t5 >= 5'd15) begin
            v_t5 = v_t5 - 5'd15;
        end else if (v_t5 >= 5'd10) begin
            v_t5 = v_t5 - 5'd10;
        end else if (v_t5 >= 5'd5) begin
            v_t5 = v_t5 - 5'd5;
        end
        n_m5  = v_t5[2:0];
        n_m33 = 11'(r_s33[9:0]) + 11'(r_s33[11:10]);
    end

    // Third step: rebuild param mod 35 from its residues mod 7 and mod 5, and
    // finish param mod 33 using 32 = -1 mod 33.
    t_clk_ovr n_ovr;
    t_clk_ovr r_ovr;

    always_comb begin
        logic [7:0] v_r35;
        logic [6:0] v_r33;
        v_r35 = 8'(8'(r_m7) * 8'd15) + 8'(8'(r_m5) * 8'd21);
        if (v_r35 >= 8'd140) begin
            v_r35 = v_r35 - 8'd140;
        end else if (v_r35 >= 8'd105) begin
            v_r35 = v_r35 - 8'd105;
        end else if (v_r35 >= 8'd70) begin
            v_r35 = v_r35 - 8'd70;
        end else if (v_r35 >= 8'd35) begin
            v_r35 = v_r35 - 8'd35;
        end
        if (v_r35 >= 8'd28) begin
            n_ovr.bright = 3'd4;
        end else if (v_r35 >= 8'd21) begin
            n_ovr.bright = 3'd3;
        end else if (v_r35 >= 8'd14) begin
            n_ovr.bright = 3'd2;
        end else if (v_r35 >= 8'd7) begin
            n_ovr.bright = 3'd1;
        end else begin
            n_ovr.bright = 3'd0;
        end
        v_r33 = 7'(r_m33[4:0]) + 7'd33 - 7'(r_m33[10:5]);
        if (v_r33 >= 7'd33) begin
            v_r33 = v_r33 - 7'd33;
        end
        if (v_r33 >= 7'd22) begin
            n_ovr.sat_div = 2'd2;
        end else if (v_r33 >= 7'd11) begin
            n_ovr.sat_div = 2'd1;
        end else begin
            n_ovr.sat_div = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7  <= n_s7;
        r_s5  <= n_s5;
        r_s33 <= n_s33;
        r_m7  <= n_m7;
        r_m5  <= n_m5;
        r_m33 <= n_m33;
        r_ovr <= n_ovr;
    end

    assign o_ovr = r_ovr;

endmodule

`default_nettype wire

// ===== sv/led_palette_gradient_pixel.sv =====
// Top level of the LED palette gradient pixel block: key, blend and output pipeline.
//
// The block turns one LED description per beat into one HSV colour per beat.
// Input beats arrive on the i_s_axis channel (index, radius, angle, branch and
// animation phase); result beats leave on the o_m_axis channel (index echo, hue,
// saturation, brightness). The effect mode, effect parameter and six palette
// entries are written through a separate configuration channel that is always
// ready; writes are meant to happen while no beat is in flight.
// The datapath is four register stages: position key and phase sum, palette
// segment select and differences, the three 8x8 products, and the divide by 255
// with the clock-mode override into the output register. One beat is taken per
// cycle for as long as the receiver keeps up.
// Each stage has its own valid bit and only holds when the stage after it is
// full and cannot move, so bubbles are squeezed out and a stalled receiver
// backs the pipeline up one stage at a time without losing or repeating a beat.
// A side pipeline of three registers reduces the effect parameter to the clock
// override values.
// Synchronous reset empties all stages and loads the documented register defaults.
`default_nettype none

module led_palette_gradient_pixel
    import lpg_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input beat fields, low bit first: led_index[4:0], radius[12:5],
    // angle[20:13], branch[28:21], phase[39:29].
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Result beat fields, low bit first: led_out_index[4:0], hue[12:5],
    // saturation[20:13], brightness[28:21], zeros[31:29].
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // Configuration writes.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int KW = $clog2(LED_COUNT + 1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [2:0]  r_effect_mode;
    logic [30:0] r_effect_param;
    logic [23:0] r_palette [6];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_mode  <= MODE_RST;
            r_effect_param <= PARAM_RST;
            for (int i = 0; i < 6; i++) begin
                r_palette[i] <= PAL_RST[i];
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_MODE:  r_effect_mode  <= i_cfg_data[2:0];
                CFG_PARAM: r_effect_param <= i_cfg_data[30:0];
                CFG_PAL0:  r_palette[0]   <= i_cfg_data[23:0];
                CFG_PAL1:  r_palette[1]   <= i_cfg_data[23:0];
                CFG_PAL2:  r_palette[2]   <= i_cfg_data[23:0];
                CFG_PAL3:  r_palette[3]   <= i_cfg_data[23:0];
                CFG_PAL4:  r_palette[4]   <= i_cfg_data[23:0];
                CFG_PAL5:  r_palette[5]   <= i_cfg_data[23:0];
                default:   r_effect_mode  <= r_effect_mode;
            endcase
        end
    end

    // Clock override values, derived from the parameter by a side pipeline.
    t_clk_ovr w_ovr;

    lpg_param_res u_param_res (
        .i_clk   (i_clk),
        .i_param (r_effect_param),
        .o_ovr   (w_ovr)
    );

    // ------------------------------------------------------------------
    // Stage handshakes: each stage moves when the next one has room.
    // ------------------------------------------------------------------
    logic r1_valid;
    logic r2_valid;
    logic r3_valid;
    logic r_out_valid;
    logic w_en1;
    logic w_en2;
    logic w_en3;
    logic w_en4;

    assign w_en4           = !r_out_valid || i_m_axis_tready;
    assign w_en3           = !r3_valid || w_en4;
    assign w_en2           = !r2_valid || w_en3;
    assign w_en1           = !r1_valid || w_en2;
    assign o_s_axis_tready = w_en1;
    assign o_m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_valid <= i_s_axis_tvalid;
            end
            if (w_en2) begin
                r2_valid <= r1_valid;
            end
            if (w_en3) begin
                r3_valid <= r2_valid;
            end
            if (w_en4) begin
                r_out_valid <= r3_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: position key and phase sum.
    // ------------------------------------------------------------------
    logic [4:0]  w_idx;
    logic [7:0]  w_rad;
    logic [7:0]  w_ang;
    logic [7:0]  w_br;
    logic [10:0] w_phase;

    assign w_idx   = i_s_axis_tdata[4:0];
    assign w_rad   = i_s_axis_tdata[12:5];
    assign w_ang   = i_s_axis_tdata[20:13];
    assign w_br    = i_s_axis_tdata[28:21];
    assign w_phase = i_s_axis_tdata[39:29];

    // Key table for the all mode: k * 1536 / LED_COUNT for every reachable k.
    logic [10:0] w_all_key [LED_COUNT+1];

    for (genvar g = 0; g <= LED_COUNT; g++) begin : g_all_key
        assign w_all_key[g] = 11'((g * 1536) / LED_COUNT);
    end

    logic [12:0] n1_sum;
    logic        n1_ovr;

    always_comb begin
        logic [10:0] v_ph_sat;
        logic [10:0] v_ph;
        logic        v_mir;
        logic        v_low_br;
        logic        v_mix_odd;
        logic [7:0]  v_k;
        logic [18:0] v_rprod;
        logic [10:0] v_key;
        logic [7:0]  v_ki;

        v_ph_sat = (w_phase > PHASE_MAX) ? PHASE_MAX : w_phase;
        v_ph     = r_effect_param[0] ? (PHASE_MAX - v_ph_sat) : v_ph_sat;
        v_mir    = r_effect_param[1];
        v_low_br = (w_br < 8'd30);
        // (angle + 20) / 43 is odd exactly in these three angle bands.
        v_mix_odd = (w_ang >= 8'd23  && w_ang < 8'd66)
                 || (w_ang >= 8'd109 && w_ang < 8'd152)
                 || (w_ang >= 8'd195 && w_ang < 8'd238);

        v_k     = '0;
        v_rprod = '0;
        v_key   = '0;
        v_ki    = '0;
        n1_sum  = '0;
        n1_ovr  = 1'b0;

        case (t_mode'(r_effect_mode))
            MODE_RADIAL: begin
                v_k     = v_mir ? ~w_rad : w_rad;
                v_rprod = 19'(v_k) * 19'd1380;
                n1_sum  = 13'(v_ph) + 13'(v_rprod[18:8]);
            end
            MODE_CLOCK: begin
                v_k = w_ang;
                if (r_effect_param[3] && v_low_br) begin
                    v_k = ~v_k;
                end
                if (v_mir) begin
                    v_k = ~v_k;
                end
                n1_sum = 13'(v_ph) + 13'(11'(v_k) * 11'd6);
                n1_ovr = r_effect_param[2] && v_low_br;
            end
            MODE_RADIAL_MIX: begin
                v_k     = v_mix_odd ? ~w_rad : w_rad;
                v_rprod = 19'(v_k) * 19'd1380;
                n1_sum  = 13'({v_ph, 1'b0}) + 13'(v_rprod[18:8]);
            end
            MODE_SPIRAL: begin
                v_k = w_ang + 8'(w_rad[7:2]);
                if (v_mir) begin
                    v_k = ~v_k;
                end
                n1_sum = 13'(v_ph) + 13'(11'(v_k) * 11'd6);
            end
            MODE_TREE: begin
                v_k    = v_mir ? ~w_br : w_br;
                n1_sum = 13'(v_ph) + 13'(11'(v_k) * 11'd6);
            end
            default: begin
                // Out-of-range indexes are clamped to the last LED.
                v_ki = ({3'b000, w_idx} > 8'(LED_COUNT - 1)) ? 8'(LED_COUNT - 1)
                                                              : {3'b000, w_idx};
                if (v_mir) begin
                    v_ki = 8'(LED_COUNT) - v_ki;
                end
                v_key  = w_all_key[v_ki[KW-1:0]];
                n1_sum = 13'(v_ph) + 13'(v_key);
            end
        endcase
    end

    logic [4:0]  r1_idx;
    logic [12:0] r1_sum;
    logic        r1_ovr;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_idx <= w_idx;
            r1_sum <= n1_sum;
            r1_ovr <= n1_ovr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: palette segment, fraction, and the per-channel differences.
    // ------------------------------------------------------------------
    logic [2:0]  w_seg;
    logic [23:0] w_c1;
    logic [23:0] w_c2;

    always_comb begin
        logic [4:0] v_s;
        v_s = r1_sum[12:8];
        if (v_s >= 5'd12) begin
            v_s = v_s - 5'd12;
        end
        if (v_s >= 5'd6) begin
            v_s = v_s - 5'd6;
        end
        w_seg = v_s[2:0];
    end

    always_comb begin
        case (w_seg)
            3'd1: begin
                w_c1 = r_palette[1];
                w_c2 = r_palette[2];
            end
            3'd2: begin
                w_c1 = r_palette[2];
                w_c2 = r_palette[3];
            end
            3'd3: begin
                w_c1 = r_palette[3];
                w_c2 = r_palette[4];
            end
            3'd4: begin
                w_c1 = r_palette[4];
                w_c2 = r_palette[5];
            end
            3'd5: begin
                w_c1 = r_palette[5];
                w_c2 = r_palette[0];
            end
            default: begin
                w_c1 = r_palette[0];
                w_c2 = r_palette[1];
            end
        endcase
    end

    // Channel 2 is hue, 1 is saturation, 0 is value, matching the packing.
    logic [7:0] n2_base [3];
    logic [7:0] n2_mag  [3];
    logic       n2_neg  [3];

    always_comb begin
        logic [7:0] v_d;
        // Hue takes the shorter way around the colour wheel.
        v_d        = w_c2[23:16] - w_c1[23:16];
        n2_base[2] = w_c1[23:16];
        n2_neg[2]  = v_d[7];
        n2_mag[2]  = v_d[7] ? (~v_d + 8'd1) : v_d;
        for (int c = 0; c < 2; c++) begin
            n2_base[c] = w_c1[8*c +: 8];
            n2_neg[c]  = !(w_c2[8*c +: 8] > w_c1[8*c +: 8]);
            n2_mag[c]  = n2_neg[c] ? (w_c1[8*c +: 8] - w_c2[8*c +: 8])
                                   : (w_c2[8*c +: 8] - w_c1[8*c +: 8]);
        end
    end

    logic [4:0] r2_idx;
    logic       r2_ovr;
    logic [7:0] r2_frac;
    logic [7:0] r2_base [3];
    logic [7:0] r2_mag  [3];
    logic       r2_neg  [3];

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_idx  <= r1_idx;
            r2_ovr  <= r1_ovr;
            r2_frac <= r1_sum[7:0];
            for (int c = 0; c < 3; c++) begin
                r2_base[c] <= n2_base[c];
                r2_mag[c]  <= n2_mag[c];
                r2_neg[c]  <= n2_neg[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: difference times fraction, one 8x8 product per channel.
    // ------------------------------------------------------------------
    logic [4:0]  r3_idx;
    logic        r3_ovr;
    logic [7:0]  r3_base [3];
    logic        r3_neg  [3];
    logic [15:0] r3_prod [3];

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_idx <= r2_idx;
            r3_ovr <= r2_ovr;
            for (int c = 0; c < 3; c++) begin
                r3_base[c] <= r2_base[c];
                r3_neg[c]  <= r2_neg[c];
                r3_prod[c] <= 16'(r2_mag[c]) * 16'(r2_frac);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: truncating divide by 255, step from the base, clock override.
    // ------------------------------------------------------------------
    logic [7:0] w_res [3];

    always_comb begin
        logic [16:0] v_q;
        for (int c = 0; c < 3; c++) begin
            // floor(x / 255) = (x + (x >> 8) + 1) >> 8 for every product here.
            v_q      = 17'(r3_prod[c]) + 17'(r3_prod[c][15:8]) + 17'd1;
            w_res[c] = r3_neg[c] ? (r3_base[c] - v_q[15:8]) : (r3_base[c] + v_q[15:8]);
        end
    end

    logic [7:0] n_out_sat;
    logic [7:0] n_out_val;

    always_comb begin
        n_out_sat = w_res[1];
        n_out_val = w_res[0];
        if (r3_ovr) begin
            n_out_val = 8'(w_ovr.bright);
            // A divisor of zero or one leaves saturation as it is.
            if (w_ovr.sat_div == 2'd2) begin
                n_out_sat = {1'b0, w_res[1][7:1]};
            end
        end
    end

    logic [OUT_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out_data <= {3'b000, n_out_val, n_out_sat, w_res[2], r3_idx};
        end
    end

    assign o_m_axis_tdata = r_out_data;

endmodule

`default_nettype wire

// ===== sv/lpg_checker.sv =====
// Port-level checker for the LED palette gradient pixel block, bound to the top level.
`default_nettype none

module lpg_checker
    import lpg_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat valid right after reset");

    // A result beat the receiver has not taken stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed or dropped");

    // Pad bits above the brightness field are always zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[31:29] == 3'b000)
        else $error("result pad bits not zero");

    // With the receiver ready throughout, an accepted beat shows up at the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) ##1 i_m_axis_tready ##1 i_m_axis_tready
            ##1 i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted beat did not reach the output in four cycles");

endmodule

bind led_palette_gradient_pixel lpg_checker u_lpg_checker (.*);

`default_nettype wire
